>>> src/slcan_pkg.sv
`default_nettype none
package slcan_pkg;

  // ASCII codes of the frame syntax
  localparam logic [7:0] CH_START = 8'h74;  // 't'
  localparam logic [7:0] CH_CR    = 8'h0D;  // carriage return
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;

  localparam int         NUM_DATA = 8;
  localparam logic [3:0] MAX_LEN  = 4'd8;
  // 't', three id digits and the length digit come before the data
  localparam int         HDR_LEN  = 5;

  typedef struct packed {
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [11:0] frame_id;
    logic [3:0]  byte_count;
    logic [7:0]  data_0;
    logic [7:0]  data_1;
    logic [7:0]  data_2;
    logic [7:0]  data_3;
    logic [7:0]  data_4;
    logic [7:0]  data_5;
    logic [7:0]  data_6;
    logic [7:0]  data_7;
    logic        malformed;
  } out_item_t;

  // classification of one received character
  typedef struct packed {
    logic       is_start;
    logic       is_cr;
    logic       is_hex;
    logic [3:0] hex_val;   // zero when not a hex digit
    logic       is_dec;
    logic [3:0] dec_val;   // zero when not a decimal digit
  } char_info_t;

endpackage
`default_nettype wire

>>> src/slcan_stream_if.sv
`default_nettype none
interface slcan_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> src/slcan_char_decode.sv
`default_nettype none
module slcan_char_decode
  import slcan_pkg::*;
(
  input  wire logic [7:0] ch,
  output char_info_t      info
);

  logic is_digit, is_upper, is_lower;

  always_comb begin
    is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    is_upper = (ch >= CH_UC_A) && (ch <= CH_UC_F);
    is_lower = (ch >= CH_LC_A) && (ch <= CH_LC_F);

    info.is_start = (ch == CH_START);
    info.is_cr    = (ch == CH_CR);
    info.is_hex   = is_digit | is_upper | is_lower;
    info.is_dec   = is_digit;
    info.dec_val  = is_digit ? 4'(ch - CH_ZERO) : 4'd0;

    if (is_digit) begin
      info.hex_val = 4'(ch - CH_ZERO);
    end else if (is_upper) begin
      info.hex_val = 4'(ch - CH_UC_A + 8'd10);
    end else if (is_lower) begin
      info.hex_val = 4'(ch - CH_LC_A + 8'd10);
    end else begin
      info.hex_val = 4'd0;
    end
  end

endmodule
`default_nettype wire

>>> src/slcan_frame_core.sv
`default_nettype none
module slcan_frame_core
  import slcan_pkg::*;
#(
  parameter int MAX_FRAME = 256
)
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] in_byte,
  output logic            push,
  output out_item_t       res
);

  localparam int POS_W = $clog2(MAX_FRAME);

  logic [POS_W-1:0] pos, pos_next;
  logic [11:0]      id_acc, id_acc_next;
  logic [3:0]       len, len_next;
  logic [3:0]       hi_nib, hi_nib_next;
  logic [7:0]       payload [NUM_DATA];
  logic [7:0]       payload_next [NUM_DATA];
  logic             err, err_next;

  char_info_t       info;
  logic [POS_W-1:0] min_len;
  logic [POS_W-1:0] dpos;
  logic [POS_W-2:0] idx;

  slcan_char_decode u_dec (
    .ch   (in_byte),
    .info (info)
  );

  always_comb begin
    min_len = POS_W'(HDR_LEN) + POS_W'({len, 1'b0});
    dpos    = pos - POS_W'(HDR_LEN);
    idx     = dpos[POS_W-1:1];

    res.frame_id   = id_acc;
    res.byte_count = len;
    res.data_0     = payload[0];
    res.data_1     = payload[1];
    res.data_2     = payload[2];
    res.data_3     = payload[3];
    res.data_4     = payload[4];
    res.data_5     = payload[5];
    res.data_6     = payload[6];
    res.data_7     = payload[7];
    res.malformed  = err | (pos < min_len);
  end

  always_comb begin
    pos_next    = pos;
    id_acc_next = id_acc;
    len_next    = len;
    hi_nib_next = hi_nib;
    payload_next = payload;
    err_next    = err;
    push        = 1'b0;

    if (accept) begin
      if (pos == '0) begin
        if (info.is_start) begin
          id_acc_next = '0;
          len_next    = '0;
          hi_nib_next = '0;
          for (int k = 0; k < NUM_DATA; k++) payload_next[k] = '0;
          err_next    = 1'b0;
          pos_next    = POS_W'(1);
        end
      end else if (info.is_cr) begin
        push     = 1'b1;
        pos_next = '0;
      end else begin
        if (pos <= POS_W'(3)) begin
          id_acc_next = {id_acc[7:0], info.hex_val};
          if (!info.is_hex) err_next = 1'b1;
        end else if (pos == POS_W'(4)) begin
          if (!info.is_dec) begin
            err_next = 1'b1;
            len_next = '0;
          end else if (info.dec_val > MAX_LEN) begin
            err_next = 1'b1;
            len_next = MAX_LEN;
          end else begin
            len_next = info.dec_val;
          end
        end else if (idx < (POS_W-1)'(len)) begin
          if (!info.is_hex) err_next = 1'b1;
          if (!dpos[0]) begin
            hi_nib_next = info.hex_val;
          end else begin
            payload_next[idx[2:0]] = {hi_nib, info.hex_val};
          end
        end
        // overlong frame: drop it and wait for the next start
        if (pos == POS_W'(MAX_FRAME - 1)) pos_next = '0;
        else pos_next = pos + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      id_acc <= '0;
      len    <= '0;
      hi_nib <= '0;
      err    <= 1'b0;
      for (int k = 0; k < NUM_DATA; k++) payload[k] <= '0;
    end else begin
      pos    <= pos_next;
      id_acc <= id_acc_next;
      len    <= len_next;
      hi_nib <= hi_nib_next;
      err    <= err_next;
      payload <= payload_next;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_W'(MAX_FRAME - 1))
    else $error("frame position out of range");

  a_len_sat: assert property (@(posedge clk) disable iff (rst)
    push |-> res.byte_count <= MAX_LEN)
    else $error("byte count above 8");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (push && res.byte_count == 4'd0) |->
      (res.data_0 == 8'd0 && res.data_1 == 8'd0 && res.data_7 == 8'd0))
    else $error("unused data byte not zero");

  a_cr_ends: assert property (@(posedge clk) disable iff (rst)
    push |=> pos == '0)
    else $error("parser not idle after frame end");

endmodule
`default_nettype wire

>>> src/slcan_out_stage.sv
`default_nettype none
module slcan_out_stage
  import slcan_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  out_item_t      push_item,
  output logic           space,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  logic [1:0] count, count_next;
  out_item_t  slot0, slot1;
  logic       pop;

  assign pop       = out_valid & out_ready;
  assign out_valid = (count != 2'd0);
  assign out_item  = slot0;
  assign space     = (count != 2'd2);

  always_comb begin
    count_next = count;
    priority if (push && !pop) count_next = count + 2'd1;
    else if (pop && !push)     count_next = count - 2'd1;
    else                       count_next = count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (count == 2'd1) begin
        slot0 <= push_item;
      end else begin
        slot0 <= slot1;
        slot1 <= push_item;
      end
    end else if (pop) begin
      slot0 <= slot1;
    end else if (push) begin
      if (count == 2'd0) slot0 <= push_item;
      else slot1 <= push_item;
    end
  end

endmodule
`default_nettype wire

>>> src/slcan_frame_parser.sv
// slcan_frame_parser: ASCII standard CAN frame ('t' iii l dd.. CR) to decoded frame items.
// Throughput: one character item accepted per cycle, sustained, set by the single
//   frame-state register update; ready drops only while both result slots are full.
// Result: a frame item is registered into a result slot when its carriage return is accepted.
// Reset (rst, synchronous, active high): parser idle waiting for 't', result
//   slots empty; no clearing pass.
`default_nettype none
module slcan_frame_parser
  import slcan_pkg::*;
#(
  parameter int MAX_FRAME = 256   // 32..512 characters before a frame is dropped
)
(
  input  wire logic      clk,
  input  wire logic      rst,
  slcan_stream_if.sink   in_chan,
  slcan_stream_if.source out_chan
);

  // Character items are accepted straight into the frame state registers.
  logic      accept;
  logic      space;
  logic      push;
  out_item_t push_item;
  out_item_t out_item;
  in_item_t  in_item;

  assign in_item       = in_chan.payload;
  assign in_chan.ready = space;
  assign accept        = in_chan.valid & space;

  // Frame state: position counter, id/length/data accumulation, error flag.
  slcan_frame_core #(
    .MAX_FRAME (MAX_FRAME)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_item.in_byte),
    .push    (push),
    .res     (push_item)
  );

  // Two result slots, so a carriage return can still be taken while the
  // previous frame item waits at the output.
  slcan_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .space     (space),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_item  (out_item)
  );

  assign out_chan.payload = out_item;

endmodule
`default_nettype wire

>>> tb/slcan_frame_check.sv
`timescale 1ns / 100ps
module slcan_frame_check
  import slcan_pkg::*;
#(
  parameter int MAX_FRAME = 256
)
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic in_ready,
  input  in_item_t  in_item,
  input  wire logic out_valid,
  input  wire logic out_ready,
  input  out_item_t out_item,
  output int        mismatches,
  output int        pending,
  output int        frames_done,
  output int        flagged
);

  // parser state, mirrors the block
  logic [9:0]  char_pos;
  logic [11:0] id_acc;
  logic [3:0]  len_q;
  logic [3:0]  upper_nib;
  logic [7:0]  payload_q [8];
  logic        frame_err;

  out_item_t   expected_frames [$];
  out_item_t   want;
  logic [63:0] want_data;
  logic [63:0] got_data;

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return {1'b0, 4'(c - CH_ZERO)};
    if (c >= CH_UC_A && c <= CH_UC_F) return {1'b0, 4'(c - CH_UC_A + 8'd10)};
    if (c >= CH_LC_A && c <= CH_LC_F) return {1'b0, 4'(c - CH_LC_A + 8'd10)};
    return 5'h10;
  endfunction

  task automatic parse_char(input logic [7:0] c);
    logic [4:0] nib;
    logic [2:0] idx;
    int         d;
    out_item_t  f;
    if (char_pos == '0) begin
      if (c == CH_START) begin
        id_acc    = '0;
        len_q     = '0;
        upper_nib = '0;
        frame_err = 1'b0;
        foreach (payload_q[k]) payload_q[k] = '0;
        char_pos  = 10'd1;
      end
      return;
    end
    if (c == CH_CR) begin
      f.frame_id   = id_acc;
      f.byte_count = len_q;
      f.data_0     = payload_q[0];
      f.data_1     = payload_q[1];
      f.data_2     = payload_q[2];
      f.data_3     = payload_q[3];
      f.data_4     = payload_q[4];
      f.data_5     = payload_q[5];
      f.data_6     = payload_q[6];
      f.data_7     = payload_q[7];
      // short frame: CR before all header and data characters
      f.malformed  = frame_err || (int'(char_pos) < HDR_LEN + 2 * int'(len_q));
      expected_frames.push_back(f);
      char_pos = '0;
      return;
    end
    nib = hex_nibble(c);
    if (char_pos <= 10'd3) begin
      if (nib[4]) begin
        frame_err = 1'b1;
        nib = '0;
      end
      id_acc = {id_acc[7:0], nib[3:0]};
    end else if (char_pos == 10'd4) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        len_q = 4'(c - CH_ZERO);
        if (len_q > MAX_LEN) begin
          frame_err = 1'b1;
          len_q = MAX_LEN;
        end
      end else begin
        frame_err = 1'b1;
        len_q = '0;
      end
    end else begin
      d = int'(char_pos) - HDR_LEN;
      // characters past the given length are ignored
      if ((d >> 1) < int'(len_q)) begin
        idx = 3'(d >> 1);
        if (nib[4]) begin
          frame_err = 1'b1;
          nib = '0;
        end
        if (d[0] == 1'b0) upper_nib = nib[3:0];
        else payload_q[idx] = {upper_nib, nib[3:0]};
      end
    end
    // overlong frame is dropped silently
    if (int'(char_pos) + 1 >= MAX_FRAME) char_pos = '0;
    else char_pos = char_pos + 10'd1;
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      char_pos    = '0;
      id_acc      = '0;
      len_q       = '0;
      upper_nib   = '0;
      frame_err   = 1'b0;
      foreach (payload_q[k]) payload_q[k] = '0;
      expected_frames.delete();
      mismatches  = 0;
      pending     = 0;
      frames_done = 0;
      flagged     = 0;
    end else begin
      if (in_valid && in_ready) parse_char(in_item.in_byte);
      if (out_valid && out_ready) begin
        if (expected_frames.size() == 0) begin
          $error("frame id %0h arrived with none expected", out_item.frame_id);
          mismatches++;
        end else begin
          want = expected_frames.pop_front();
          check_field("frame_id", int'(want.frame_id), int'(out_item.frame_id));
          check_field("byte_count", int'(want.byte_count), int'(out_item.byte_count));
          want_data = {want.data_7, want.data_6, want.data_5, want.data_4,
                       want.data_3, want.data_2, want.data_1, want.data_0};
          got_data  = {out_item.data_7, out_item.data_6, out_item.data_5, out_item.data_4,
                       out_item.data_3, out_item.data_2, out_item.data_1, out_item.data_0};
          for (int k = 0; k < NUM_DATA; k++)
            check_field($sformatf("data_%0d", k), int'(want_data[8*k +: 8]),
                        int'(got_data[8*k +: 8]));
          check_field("malformed", int'(want.malformed), int'(out_item.malformed));
          frames_done++;
          if (want.malformed) flagged++;
        end
      end
      pending = expected_frames.size();
    end
  end

endmodule

>>> tb/slcan_frame_parser_test.sv
`timescale 1ns / 100ps
module slcan_frame_parser_test
  import slcan_pkg::*;
();

  typedef logic [7:0] char_q_t [$];

  localparam int MAX_FRAME = 256;

  logic clk;
  logic rst = 1'b1;

  // 100 MHz
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  slcan_stream_if #(.T(in_item_t))  in_chan ();
  slcan_stream_if #(.T(out_item_t)) out_chan ();

  slcan_frame_parser #(.MAX_FRAME(MAX_FRAME)) dut (
    .clk      (clk),
    .rst      (rst),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  int mismatches;
  int pending;
  int frames_done;
  int flagged;

  slcan_frame_check #(.MAX_FRAME(MAX_FRAME)) frame_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_chan.valid),
    .in_ready    (in_chan.ready),
    .in_item     (in_chan.payload),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .out_item    (out_chan.payload),
    .mismatches  (mismatches),
    .pending     (pending),
    .frames_done (frames_done),
    .flagged     (flagged)
  );

  // quiet: neither side idles; hold_req: receiver backs off for a long stretch
  bit quiet    = 1'b0;
  bit hold_req = 1'b0;
  int chars_sent  = 0;

  // hex digit for a nibble, letters in either case at random
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return CH_ZERO + 8'(n);
    return ($urandom_range(1) ? CH_UC_A : CH_LC_A) + 8'(n) - 8'd10;
  endfunction

  // 't' iii l then pairs data bytes, byte 0 first, closing CR
  function automatic char_q_t build_frame(input logic [11:0] id, input logic [7:0] len_ch,
                                          input int pairs, input logic [63:0] data);
    char_q_t q;
    q.push_back(CH_START);
    for (int i = 0; i < 3; i++) q.push_back(hex_char(id[11 - 4*i -: 4]));
    q.push_back(len_ch);
    for (int k = 0; k < pairs; k++) begin
      q.push_back(hex_char(data[8*k + 4 +: 4]));
      q.push_back(hex_char(data[8*k +: 4]));
    end
    q.push_back(CH_CR);
    return q;
  endfunction

  // one character item; called and returns at a falling edge
  task automatic send_char(input logic [7:0] c);
    while (!quiet && $urandom_range(99) < 38) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.payload.in_byte <= c;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
    chars_sent++;
  endtask

  task automatic send_seq(input char_q_t s);
    foreach (s[i]) send_char(s[i]);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_line(input string s);
    send_text(s);
    send_char(CH_CR);
  endtask

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_chan.ready <= 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else if (!quiet && $urandom_range(99) < 38) begin
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // sender
  initial begin
    char_q_t f;
    int      sel;
    int      len;
    int      keep;
    int      at;
    bit      pressure_done;
    logic [7:0] b;

    pressure_done = 1'b0;
    in_chan.valid   <= 1'b0;
    in_chan.payload <= '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // --- directed ---
    // bytes outside a frame: dropped
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CH_CR);
    send_text("x5");
    // smallest and largest well-formed frames
    send_line("t0000");
    send_line("tFFF8FFFFFFFFFFFFFFFF");
    // hex digits of both cases in the data
    send_line("tabc8a1B2c3D4e5F60789");
    // non-hex id digit
    send_line("t1G32AABB");
    // length digit not decimal
    send_line("t123x");
    // length 9 saturates at 8 and flags the frame
    send_line("t12390011223344556677");
    // non-hex data character
    send_line("t0012Z133");
    // extra data characters past the length
    send_line("t0011ABCDEF");
    // short frames, one ending on a lone upper nibble
    send_line("t");
    send_line("t12");
    send_line("t1234AB");
    send_line("t0012ABC");
    // 't' taken as an ordinary character inside a frame
    send_line("tt1t1tt");
    // characters just outside each hex range
    send_line("t@G`8/:gG0F9fAa");
    send_line("t000:");
    send_line("t000/");
    // longest frame that still completes
    send_char(CH_START);
    repeat (MAX_FRAME - 2) send_char("5");
    send_char(CH_CR);
    // overlong frame: dropped, the CR after it falls outside a frame
    send_char(CH_START);
    repeat (MAX_FRAME - 1) send_char("A");
    send_char(CH_CR);
    send_line("t7FF1FF");

    // --- random ---
    while (chars_sent < 1200) begin
      sel      = $urandom_range(99);
      len      = $urandom_range(8);
      f = build_frame(12'($urandom), CH_ZERO + 8'(len), len, {$urandom, $urandom});
      if (sel < 65) begin
        // well-formed as built
      end else if (sel < 85) begin
        case ($urandom_range(3))
          0: begin
            // cut short
            keep = $urandom_range(f.size() - 2, 1);
            while (f.size() > keep) void'(f.pop_back());
            f.push_back(CH_CR);
          end
          1: begin
            at = $urandom_range(f.size() - 2, 1);
            f[at] = 8'($urandom_range(255));
          end
          2: f[4] = $urandom_range(1) ? CH_NINE : 8'($urandom_range(255));
          default: begin
            void'(f.pop_back());
            repeat ($urandom_range(4, 1)) f.push_back(hex_char(4'($urandom_range(15))));
            f.push_back(CH_CR);
          end
        endcase
      end else if (sel < 93) begin
        // line noise between frames
        f.delete();
        repeat ($urandom_range(6, 1)) begin
          b = 8'($urandom_range(255));
          if (b != CH_START) f.push_back(b);
        end
      end else begin
        // frame of arbitrary bytes
        f.delete();
        f.push_back(CH_START);
        repeat ($urandom_range(20)) f.push_back(8'($urandom_range(255)));
        f.push_back(CH_CR);
      end
      send_seq(f);
      if (!pressure_done && chars_sent >= 750) begin
        hold_req      = 1'b1;
        pressure_done = 1'b1;
      end
      quiet = (chars_sent >= 900 && chars_sent < 1050);
    end
    in_chan.valid <= 1'b0;
    quiet = 1'b0;

    wait (pending == 0);
    repeat (20) @(posedge clk);
    $display("%0d characters sent; %0d frames checked, %0d of them malformed",
             chars_sent, frames_done, flagged);
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
